// ===== src/awas_pkg.sv =====
package awas_pkg;

  localparam int CODE_W = 12;
  localparam int READ_W = 16;
  localparam int SUM_W  = 24;
  localparam int CFG_W  = 16;
  localparam int DVD_W  = 30;
  localparam int DVS_W  = 12;
  localparam int NUM_W  = 31;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_READ_CUR0 = 2'd1,
    CMD_READ_CUR1 = 2'd2,
    CMD_READ_PRES = 2'd3
  } cmd_t;

  localparam logic REG_PRES_MIN = 1'b0;
  localparam logic REG_PRES_OFS = 1'b1;

  // code * 60000 / ref for current, code * 153511 / (ref * 64) for pressure
  localparam logic [DVD_W-1:0] CUR_GAIN  = 30'd60000;
  localparam logic [DVD_W-1:0] PRES_GAIN = 30'd153511;
  localparam int               PRES_GAIN_SHIFT = 6;

  // pressure read: ((avg - 200) * 28 + 125 * offset) / 125
  localparam int PRES_SLOPE = 28;
  localparam int PRES_DEN   = 125;
  localparam int PRES_BIAS  = 200 * PRES_SLOPE;

endpackage

// ===== src/adc_window_average_scaler.sv =====
// Moving average of two current channels and one pressure channel, scaled
// against the internal reference code. A sample transaction (command 0) loads,
// runs the bit-serial dividers (three side by side, one per channel), finishes
// and then updates the rings and running sums. A current read runs one division
// and moves the result into the output register once that register is free; a
// pressure read runs the divider again unless the first-pass numerator is
// negative, in which case it reads zero. A new transaction is taken only once
// the previous one has finished its work, while a finished result may still sit
// in the output register. Current reads return sum / (window - 1), pressure
// reads scale that average; a read clears that channel's sum and fill count, so
// its old ring entries read as zero until the ring refills.
module adc_window_average_scaler #(
  parameter int CURRENT_WINDOW  = 16,
  parameter int PRESSURE_WINDOW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [awas_pkg::CFG_W-1:0]    cfg_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [awas_pkg::CODE_W-1:0]   in_current_code_a,
  input  logic [awas_pkg::CODE_W-1:0]   in_current_code_b,
  input  logic [awas_pkg::CODE_W-1:0]   in_pressure_code,
  input  logic [awas_pkg::CODE_W-1:0]   in_reference_code,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [awas_pkg::READ_W-1:0]   out_reading
);

  import awas_pkg::*;

  localparam int CW_AW = (CURRENT_WINDOW > 1) ? $clog2(CURRENT_WINDOW) : 1;
  localparam int PW_AW = (PRESSURE_WINDOW > 1) ? $clog2(PRESSURE_WINDOW) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMP_DIV,
    ST_SAMP_UPD,
    ST_AVG_DIV,
    ST_PRES_DIV,
    ST_RESULT
  } state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  cmd_t                in_cmd;
  logic                ref_zero_r;
  logic [CODE_W-1:0]   pres_min_r;
  logic [CFG_W-1:0]    pres_ofs_r;
  logic [SUM_W-1:0]    sum0_r, sum1_r, sump_r;
  logic [CW_AW-1:0]    cp_r, cp_inc;
  logic [PW_AW-1:0]    pp_r, pp_inc;
  logic [CW_AW-1:0]    fill0_r, fill1_r;
  logic [PW_AW-1:0]    fillp_r;
  logic                full0, full1, fullp;
  logic [READ_W-1:0]   res_r;
  logic                out_valid_r;
  logic [READ_W-1:0]   out_reading_r;

  logic                in_accept;
  logic [CODE_W-1:0]   pres_code_clamp;
  logic [DVD_W-1:0]    cur0_prod, cur1_prod, pres_prod, pres_dvd;

  logic                d0_start, d12_start, d0_done, d1_done, d2_done;
  logic [DVD_W-1:0]    d0_dvd, d0_q, d1_q, d2_q;
  logic [DVS_W-1:0]    d0_dvs;

  logic [NUM_W-1:0]    p_slope, p_ofs, p_tot, p_num;
  logic                pres_neg;

  logic [READ_W-1:0]   v0, v1, vp;
  logic [READ_W-1:0]   ram0_rd, ram1_rd, ramp_rd;
  logic [READ_W-1:0]   old0, old1, oldp;
  logic                ring_we;

  function automatic logic [READ_W-1:0] sat16(input logic [DVD_W-1:0] q);
    sat16 = (|q[DVD_W-1:READ_W]) ? '1 : q[READ_W-1:0];
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_cmd    = cmd_t'(in_command);

  assign cp_inc = (cp_r == CW_AW'(CURRENT_WINDOW - 1)) ? '0 : cp_r + 1'b1;
  assign pp_inc = (pp_r == PW_AW'(PRESSURE_WINDOW - 1)) ? '0 : pp_r + 1'b1;

  // scaled dividends; the pressure /64 comes off the top before dividing by ref
  assign pres_code_clamp = (in_pressure_code < pres_min_r) ? pres_min_r : in_pressure_code;
  assign cur0_prod = DVD_W'(in_current_code_b) * CUR_GAIN;
  assign cur1_prod = DVD_W'(in_current_code_a) * CUR_GAIN;
  assign pres_prod = DVD_W'(pres_code_clamp) * PRES_GAIN;
  assign pres_dvd  = pres_prod >> PRES_GAIN_SHIFT;

  // pressure read numerator from the first-pass average
  assign p_slope  = NUM_W'(d0_q[SUM_W-1:0]) * NUM_W'(PRES_SLOPE);
  assign p_ofs    = NUM_W'(pres_ofs_r) * NUM_W'(PRES_DEN);
  assign p_tot    = p_slope + p_ofs;
  assign pres_neg = (p_tot < NUM_W'(PRES_BIAS));
  assign p_num    = p_tot - NUM_W'(PRES_BIAS);

  assign d12_start = in_accept && (in_cmd == CMD_SAMPLE);
  assign d0_start  = in_accept ||
                     ((state_r == ST_AVG_DIV) && d0_done && (cmd_r == CMD_READ_PRES) &&
                      !pres_neg);

  always_comb begin
    d0_dvd = DVD_W'(p_num);
    d0_dvs = DVS_W'(PRES_DEN);
    if (state_r == ST_IDLE) begin
      case (in_cmd)
        CMD_SAMPLE: begin
          d0_dvd = cur0_prod;
          d0_dvs = in_reference_code;
        end
        CMD_READ_CUR0: begin
          d0_dvd = DVD_W'(sum0_r);
          d0_dvs = DVS_W'(CURRENT_WINDOW - 1);
        end
        CMD_READ_CUR1: begin
          d0_dvd = DVD_W'(sum1_r);
          d0_dvs = DVS_W'(CURRENT_WINDOW - 1);
        end
        CMD_READ_PRES: begin
          d0_dvd = DVD_W'(sump_r);
          d0_dvs = DVS_W'(PRESSURE_WINDOW - 1);
        end
        default: begin
          d0_dvd = cur0_prod;
          d0_dvs = in_reference_code;
        end
      endcase
    end
  end

  awas_sdiv #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div0 (
    .clk(clk), .rst_n(rst_n), .start(d0_start), .dividend(d0_dvd), .divisor(d0_dvs),
    .done(d0_done), .quotient(d0_q)
  );

  awas_sdiv #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div1 (
    .clk(clk), .rst_n(rst_n), .start(d12_start), .dividend(cur1_prod),
    .divisor(in_reference_code), .done(d1_done), .quotient(d1_q)
  );

  awas_sdiv #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div2 (
    .clk(clk), .rst_n(rst_n), .start(d12_start), .dividend(pres_dvd),
    .divisor(in_reference_code), .done(d2_done), .quotient(d2_q)
  );

  // a zero reference pins every scaled value at full scale
  assign v0 = ref_zero_r ? '1 : sat16(d0_q);
  assign v1 = ref_zero_r ? '1 : sat16(d1_q);
  assign vp = ref_zero_r ? '1 : sat16(d2_q);

  assign ring_we = (state_r == ST_SAMP_UPD);

  awas_ram #(.DEPTH(CURRENT_WINDOW), .WIDTH(READ_W)) u_ring0 (
    .clk(clk), .we(ring_we), .waddr(cp_r), .wdata(v0), .raddr(cp_inc), .rdata(ram0_rd)
  );

  awas_ram #(.DEPTH(CURRENT_WINDOW), .WIDTH(READ_W)) u_ring1 (
    .clk(clk), .we(ring_we), .waddr(cp_r), .wdata(v1), .raddr(cp_inc), .rdata(ram1_rd)
  );

  awas_ram #(.DEPTH(PRESSURE_WINDOW), .WIDTH(READ_W)) u_ringp (
    .clk(clk), .we(ring_we), .waddr(pp_r), .wdata(vp), .raddr(pp_inc), .rdata(ramp_rd)
  );

  // samples since the last clear, held at window - 1; until it gets there the
  // slot leaving the window has not been written since the clear
  assign full0 = (fill0_r == CW_AW'(CURRENT_WINDOW - 1));
  assign full1 = (fill1_r == CW_AW'(CURRENT_WINDOW - 1));
  assign fullp = (fillp_r == PW_AW'(PRESSURE_WINDOW - 1));

  // slot leaving the window; a cleared slot counts as zero
  assign old0 = full0 ? ram0_rd : '0;
  assign old1 = full1 ? ram1_rd : '0;
  assign oldp = fullp ? ramp_rd : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmd_r       <= CMD_SAMPLE;
      out_valid_r <= 1'b0;
      pres_min_r  <= '0;
      pres_ofs_r  <= '0;
      sum0_r      <= '0;
      sum1_r      <= '0;
      sump_r      <= '0;
      cp_r        <= '0;
      pp_r        <= '0;
      fill0_r     <= '0;
      fill1_r     <= '0;
      fillp_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PRES_MIN: pres_min_r <= cfg_data[CODE_W-1:0];
          REG_PRES_OFS: pres_ofs_r <= cfg_data;
          default: ;
        endcase
      end

      if ((state_r == ST_RESULT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cmd_r      <= in_cmd;
            ref_zero_r <= (in_reference_code == '0);
            case (in_cmd)
              CMD_SAMPLE: state_r <= ST_SAMP_DIV;
              CMD_READ_CUR0: begin
                fill0_r <= '0;
                sum0_r  <= '0;
                state_r <= ST_AVG_DIV;
              end
              CMD_READ_CUR1: begin
                fill1_r <= '0;
                sum1_r  <= '0;
                state_r <= ST_AVG_DIV;
              end
              CMD_READ_PRES: begin
                fillp_r <= '0;
                sump_r  <= '0;
                state_r <= ST_AVG_DIV;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_SAMP_DIV: begin
          if (d0_done && d1_done && d2_done) begin
            state_r <= ST_SAMP_UPD;
          end
        end
        ST_SAMP_UPD: begin
          sum0_r      <= sum0_r + SUM_W'(v0) - SUM_W'(old0);
          sum1_r      <= sum1_r + SUM_W'(v1) - SUM_W'(old1);
          sump_r      <= sump_r + SUM_W'(vp) - SUM_W'(oldp);
          if (!full0) begin
            fill0_r <= fill0_r + 1'b1;
          end
          if (!full1) begin
            fill1_r <= fill1_r + 1'b1;
          end
          if (!fullp) begin
            fillp_r <= fillp_r + 1'b1;
          end
          cp_r        <= cp_inc;
          pp_r        <= pp_inc;
          state_r     <= ST_IDLE;
        end
        ST_AVG_DIV: begin
          if (d0_done) begin
            if (cmd_r == CMD_READ_PRES) begin
              if (pres_neg) begin
                res_r   <= '0;
                state_r <= ST_RESULT;
              end else begin
                state_r <= ST_PRES_DIV;
              end
            end else begin
              res_r   <= sat16(d0_q);
              state_r <= ST_RESULT;
            end
          end
        end
        ST_PRES_DIV: begin
          if (d0_done) begin
            res_r   <= sat16(d0_q);
            state_r <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_reading_r <= res_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_reading = out_reading_r;

endmodule

// ===== src/awas_ram.sv =====
module awas_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/awas_sdiv.sv =====
module awas_sdiv #(
  parameter int DVD_W = 30,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  // restoring division, one quotient bit per cycle; dividend bits shift out
  // at the top while quotient bits shift in at the bottom
  assign trial = {rem_r, q_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        q_r   <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
